FILE: design/tlmd_pkg.sv
`timescale 1ns / 1ps

package tlmd_pkg;

    localparam int HDR_BYTES     = 8;
    localparam int TYPE_BYTES    = 4;
    localparam int FIELD_W       = 31;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         payload_byte;
        logic               last;
        logic [FIELD_W-1:0] msg_type;
        logic [FIELD_W-1:0] msg_length;
    } result_t;

endpackage

FILE: design/type_length_message_deframer_unit.sv
`timescale 1ns / 1ps

// Type-length deframer: takes one stream byte per cycle, collects an 8-byte header
// (big-endian 32-bit type, then 32-bit length), and emits a reject result for a bad
// header (zero type, or bit 31 set in type or length), one empty-message result for
// a zero length, or one tagged result per payload byte with the final one marked.
// Throughput is one byte per cycle in both directions; a byte is taken whenever the
// result queue (QUEUE_DEPTH entries) has room, so output stalls back up through it.
// When idle, a result is written into the queue by the edge that takes its byte, then
// passes through the output register before it shows on the result port.
module type_length_message_deframer_unit
#(
    parameter int QUEUE_DEPTH = tlmd_pkg::QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         data_valid,
    output logic         data_ready,
    input  logic [7:0]   data_byte,
    output logic         result_valid,
    input  logic         result_ready,
    output logic [1:0]   kind,
    output logic [7:0]   payload_byte,
    output logic         last,
    output logic [30:0]  msg_type,
    output logic [30:0]  msg_length
);

    logic                 accept;
    logic                 push;
    tlmd_pkg::result_t    push_data;
    logic                 q_full;
    logic                 q_nonempty;
    logic                 q_pop;
    tlmd_pkg::result_t    q_data;
    tlmd_pkg::result_t    out_data;

    assign data_ready = !q_full;
    assign accept     = data_valid && data_ready;

    tlmd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .push      (push),
        .push_data (push_data)
    );

    tlmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .pop       (q_pop),
        .pop_data  (q_data)
    );

    tlmd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .out_valid  (result_valid),
        .out_ready  (result_ready),
        .out_data   (out_data)
    );

    assign kind         = out_data.kind;
    assign payload_byte = out_data.payload_byte;
    assign last         = out_data.last;
    assign msg_type     = out_data.msg_type;
    assign msg_length   = out_data.msg_length;

endmodule

FILE: design/tlmd_front.sv
`timescale 1ns / 1ps

// Header hunting and payload counting; produces at most one result per byte.
module tlmd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    output logic                push,
    output tlmd_pkg::result_t   push_data
);

    localparam int CNT_W = $clog2(tlmd_pkg::HDR_BYTES);

    logic [CNT_W-1:0]                hdr_count_reg, hdr_count_next;
    logic [31:0]                     type_word_reg, type_word_next;
    logic [31:0]                     length_word_reg, length_word_next;
    logic                            in_payload_reg, in_payload_next;
    logic [tlmd_pkg::FIELD_W-1:0]    payload_seen_reg, payload_seen_next;
    logic [tlmd_pkg::FIELD_W-1:0]    seen_inc;
    logic                            res_valid;
    logic                            last_byte;

    assign seen_inc  = payload_seen_reg + {{(tlmd_pkg::FIELD_W-1){1'b0}}, 1'b1};
    assign last_byte = (seen_inc == length_word_reg[tlmd_pkg::FIELD_W-1:0]);

    always_comb
    begin
        hdr_count_next    = hdr_count_reg;
        type_word_next    = type_word_reg;
        length_word_next  = length_word_reg;
        in_payload_next   = in_payload_reg;
        payload_seen_next = payload_seen_reg;
        res_valid         = 1'b0;
        push_data.kind         = tlmd_pkg::KIND_PAYLOAD;
        push_data.payload_byte = 8'd0;
        push_data.last         = 1'b0;

        if (in_payload_reg)
        begin
            res_valid              = 1'b1;
            push_data.payload_byte = data_byte;
            push_data.last         = last_byte;
            if (last_byte)
            begin
                in_payload_next   = 1'b0;
                payload_seen_next = '0;
                hdr_count_next    = '0;
            end
            else
            begin
                payload_seen_next = seen_inc;
            end
        end
        else
        begin
            if (hdr_count_reg < CNT_W'(tlmd_pkg::TYPE_BYTES))
                type_word_next = {type_word_reg[23:0], data_byte};
            else
                length_word_next = {length_word_reg[23:0], data_byte};

            if (hdr_count_reg != CNT_W'(tlmd_pkg::HDR_BYTES - 1))
            begin
                hdr_count_next = hdr_count_reg + CNT_W'(1);
            end
            else
            begin
                hdr_count_next = '0;
                if (type_word_next == 32'd0 || type_word_next[31] || length_word_next[31])
                begin
                    res_valid      = 1'b1;
                    push_data.kind = tlmd_pkg::KIND_REJECT;
                end
                else if (length_word_next == 32'd0)
                begin
                    res_valid      = 1'b1;
                    push_data.kind = tlmd_pkg::KIND_EMPTY;
                    push_data.last = 1'b1;
                end
                else
                begin
                    in_payload_next   = 1'b1;
                    payload_seen_next = '0;
                end
            end
        end

        push_data.msg_type   = type_word_next[tlmd_pkg::FIELD_W-1:0];
        push_data.msg_length = length_word_next[tlmd_pkg::FIELD_W-1:0];
    end

    assign push = accept & res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_count_reg    <= '0;
            type_word_reg    <= '0;
            length_word_reg  <= '0;
            in_payload_reg   <= 1'b0;
            payload_seen_reg <= '0;
        end
        else if (accept)
        begin
            hdr_count_reg    <= hdr_count_next;
            type_word_reg    <= type_word_next;
            length_word_reg  <= length_word_next;
            in_payload_reg   <= in_payload_next;
            payload_seen_reg <= payload_seen_next;
        end
    end

endmodule

FILE: design/tlmd_queue.sv
`timescale 1ns / 1ps

// Short result queue between classifier and output stage.
module tlmd_queue
#(
    parameter int DEPTH = tlmd_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tlmd_pkg::result_t   push_data,
    output logic                full,
    output logic                nonempty,
    input  logic                pop,
    output tlmd_pkg::result_t   pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlmd_pkg::result_t    slots_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

FILE: design/tlmd_back.sv
`timescale 1ns / 1ps

// Output register: refill from the queue whenever empty or being taken.
module tlmd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_nonempty,
    input  tlmd_pkg::result_t   q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output tlmd_pkg::result_t   out_data
);

    logic                 valid_reg;
    tlmd_pkg::result_t    data_reg;

    assign q_pop     = q_nonempty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || out_ready)
            valid_reg <= q_nonempty;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= q_data;
    end

endmodule

FILE: design/tlmd_checker.sv
`timescale 1ns / 1ps

module tlmd_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         result_valid,
    input  logic         result_ready,
    input  logic [1:0]   kind,
    input  logic [7:0]   payload_byte,
    input  logic         last,
    input  logic [30:0]  msg_type,
    input  logic [30:0]  msg_length
);

    // hold a stalled request
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(kind) && $stable(last)
            && $stable(payload_byte))
        else $error("result dropped or changed while stalled");

    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == tlmd_pkg::KIND_REJECT |-> !last && payload_byte == 8'd0)
        else $error("reject result carries payload or last");

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == tlmd_pkg::KIND_EMPTY |->
            last && payload_byte == 8'd0 && msg_length == 31'd0 && msg_type != 31'd0)
        else $error("malformed empty-message result");

    a_payload_header: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == tlmd_pkg::KIND_PAYLOAD |->
            msg_type != 31'd0 && msg_length != 31'd0)
        else $error("payload result under an invalid header");

    // within a message the header tags stay put from one payload byte to the next
    a_payload_tags_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && kind == tlmd_pkg::KIND_PAYLOAD && !last
            |=> !result_valid || (kind == tlmd_pkg::KIND_PAYLOAD && $stable(msg_type)
            && $stable(msg_length)))
        else $error("message interrupted before its last payload byte");

endmodule

bind type_length_message_deframer_unit tlmd_checker u_tlmd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .last         (last),
    .msg_type     (msg_type),
    .msg_length   (msg_length)
);
